// ===== hw/rtl/u8seg_pkg.sv =====
// Shared types and constants for the UTF-8 combining character segmenter.
// Holds the result record, the queue push bundle and the combining mark ranges.
// No dependencies.
package u8seg_pkg;

  // Lead/continuation test: a continuation byte has 10 in its top two bits.
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_CODE = 8'h80;

  localparam logic [3:0] LEN_MAX = 4'd15;

  localparam int NUM_RANGES = 4;

  // Half-open combining mark ranges [lo, hi) over the packed big-endian bytes.
  localparam logic [23:0] COMB_LO [NUM_RANGES] = '{
    24'h00cc80, 24'he1b780, 24'he28390, 24'hefb8a0
  };
  localparam logic [23:0] COMB_HI [NUM_RANGES] = '{
    24'h00cdb0, 24'he1b7c0, 24'he283c0, 24'hefb8b0
  };

  // Result queue geometry. The depth must be a power of two.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [3:0] cp_length;
    logic       combining;
    logic       starts_char;
    logic       closes_string;
    logic       last;
  } result_t;

  // Up to two records pushed per accepted byte, in output order.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== hw/rtl/u8seg_classify.sv =====
// Combining mark test for one code point.
// Depends on u8seg_pkg for the range table.
module u8seg_classify
  import u8seg_pkg::*;
(
  input  logic [23:0] value,
  input  logic [3:0]  length,
  output logic        combining
);

  logic [NUM_RANGES-1:0] hit;

  always_comb begin
    for (int k = 0; k < NUM_RANGES; k++) begin
      hit[k] = (value >= COMB_LO[k]) && (value < COMB_HI[k]);
    end
  end

  // Only two- and three-byte code points can be combining marks.
  assign combining = ((length == 4'd2) || (length == 4'd3)) && (|hit);

endmodule

// ===== hw/rtl/u8seg_queue.sv =====
// Small result queue: takes up to two records per cycle, gives one per beat.
// Depends on u8seg_pkg for the record types and the queue geometry.
module u8seg_queue
  import u8seg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t head,
  output logic    room_lt2
);

  result_t          entry_r [QDEPTH];
  logic [QAW-1:0]   wr_r, wr_nxt;
  logic [QAW-1:0]   rd_r, rd_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entry_r[rd_r];
  assign room_lt2  = (cnt_r > QCW'(QDEPTH - 2));

  always_comb begin
    wr_nxt  = wr_r + QAW'(push.cnt);
    rd_nxt  = rd_r + QAW'(pop);
    cnt_nxt = cnt_r + QCW'(push.cnt) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      entry_r[wr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      entry_r[wr_r + QAW'(1)] <= push.second;
    end
  end

endmodule

// ===== hw/rtl/utf8_combining_char_segmenter.sv =====
// Top level of the UTF-8 combining character segmenter.
// Depends on u8seg_pkg, u8seg_classify and u8seg_queue.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   in      | input     | in_valid/in_stall  | data_byte, string_end
//   out     | output    | out_valid/out_stall| cp_length, combining, starts_char,
//           |           |                    | closes_string, last
//
// One byte is accepted per cycle unless in_stall is high; its results are queued.
// A byte yields zero, one or two results, and the result port gives one per beat.
// A two-result byte ends a string, so the next byte gives at most one; the queue
// soaks up the extra record and the input runs at one byte per cycle unless
// out_stall holds results back.
// in_stall rises when the four-entry result queue has fewer than two free slots.
// Reset is synchronous: it empties the queue and returns to string start.
module utf8_combining_char_segmenter
  import u8seg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_string_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_cp_length,
  output logic       out_combining,
  output logic       out_starts_char,
  output logic       out_closes_string,
  output logic       out_last
);

  // State of the open code point.
  logic [23:0] pv_r, pv_nxt;
  logic [3:0]  len_r, len_nxt;
  logic        have_r, have_nxt;
  logic        start_r, start_nxt;
  logic        first_r, first_nxt;

  // Open code point after this byte, before any string end handling.
  logic [23:0] pv_new;
  logic [3:0]  len_new;
  logic        first_new;

  logic        accept;
  logic        is_lead;
  logic        open_new;
  logic        emit_old;
  logic        comb_old;
  logic        comb_new;
  logic        room_lt2;
  result_t     rec_old;
  result_t     rec_new;
  result_t     head;
  push_t       push;

  assign in_stall = room_lt2;
  assign accept   = in_valid && !in_stall;
  assign is_lead  = ((in_data_byte & CONT_MASK) != CONT_CODE);

  // The first byte of a string always opens a code point, even a continuation.
  assign open_new = start_r || !have_r || is_lead;
  assign emit_old = !start_r && have_r && is_lead;

  u8seg_classify u_class_old (
    .value     (pv_r),
    .length    (len_r),
    .combining (comb_old)
  );

  u8seg_classify u_class_new (
    .value     (pv_new),
    .length    (len_new),
    .combining (comb_new)
  );

  always_comb begin
    if (open_new) begin
      pv_new    = {16'h0000, in_data_byte};
      len_new   = 4'd1;
      first_new = start_r;
    end else begin
      // Only the last three bytes are kept; the length saturates.
      pv_new    = {pv_r[15:0], in_data_byte};
      len_new   = (len_r == LEN_MAX) ? len_r : len_r + 4'd1;
      first_new = first_r;
    end

    rec_old.cp_length     = len_r;
    rec_old.combining     = comb_old;
    rec_old.starts_char   = first_r || !comb_old;
    rec_old.closes_string = 1'b0;
    rec_old.last          = !in_string_end;

    rec_new.cp_length     = len_new;
    rec_new.combining     = comb_new;
    rec_new.starts_char   = first_new || !comb_new;
    rec_new.closes_string = 1'b1;
    rec_new.last          = 1'b1;

    // Records are pushed in output order: a closed earlier code point first.
    push.cnt    = 2'd0;
    push.first  = rec_old;
    push.second = rec_new;
    if (accept) begin
      priority if (emit_old && in_string_end) begin
        push.cnt = 2'd2;
      end else if (emit_old) begin
        push.cnt = 2'd1;
      end else if (in_string_end) begin
        push.cnt   = 2'd1;
        push.first = rec_new;
      end
    end

    pv_nxt    = pv_r;
    len_nxt   = len_r;
    have_nxt  = have_r;
    start_nxt = start_r;
    first_nxt = first_r;
    if (accept) begin
      if (in_string_end) begin
        // The string is closed: go back to string start with nothing open.
        pv_nxt    = '0;
        len_nxt   = '0;
        have_nxt  = 1'b0;
        start_nxt = 1'b1;
        first_nxt = 1'b0;
      end else begin
        pv_nxt    = pv_new;
        len_nxt   = len_new;
        have_nxt  = 1'b1;
        start_nxt = 1'b0;
        first_nxt = first_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= '0;
      len_r   <= '0;
      have_r  <= 1'b0;
      start_r <= 1'b1;
      first_r <= 1'b0;
    end else begin
      pv_r    <= pv_nxt;
      len_r   <= len_nxt;
      have_r  <= have_nxt;
      start_r <= start_nxt;
      first_r <= first_nxt;
    end
  end

  u8seg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .room_lt2  (room_lt2)
  );

  assign out_cp_length     = head.cp_length;
  assign out_combining     = head.combining;
  assign out_starts_char   = head.starts_char;
  assign out_closes_string = head.closes_string;
  assign out_last          = head.last;

  // At string start nothing may be open.
  a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(start_r && have_r))
    else $error("code point open at string start");

  // A byte that ends a string always leaves a result waiting.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_string_end) |=> out_valid)
    else $error("string end produced no result");

  // A lead byte that closes an open code point leaves a result waiting.
  a_lead_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit_old) |=> out_valid)
    else $error("closed code point produced no result");

  // The byte is never accepted when two records might not fit.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !room_lt2)
    else $error("byte accepted without queue room");

endmodule
